FILE: design/isort_pkg.sv
`timescale 1ns / 1ps

package isort_pkg;

    // Width of one sorted element, fixed by the item format
    localparam int DATA_WIDTH = 32;

    typedef logic signed [DATA_WIDTH-1:0] value_t;

    typedef struct packed {
        value_t value;
        logic   last_item;
    } in_item_t;

    typedef struct packed {
        value_t sorted_value;
        logic   last_result;
        logic   overflow;
    } out_item_t;

    // Per-cycle command broadcast to every cell of the chain
    typedef struct packed {
        logic insert;
        logic drain;
    } cell_ctrl_t;

endpackage

FILE: design/isort_cell.sv
`timescale 1ns / 1ps

module isort_cell (
    input  logic                 clk,
    input  logic                 rst_n,
    input  isort_pkg::cell_ctrl_t ctrl,
    input  isort_pkg::value_t    new_value,
    input  isort_pkg::value_t    prev_value,
    input  logic                 prev_valid,
    input  logic                 prev_gt,
    input  isort_pkg::value_t    next_value,
    input  logic                 next_valid,
    output isort_pkg::value_t    value,
    output logic                 valid,
    output logic                 gt
);

    isort_pkg::value_t value_reg;
    isort_pkg::value_t value_next;
    logic              valid_reg;
    logic              valid_next;

    // Strictly greater: an equal entry stays below the new value
    assign gt = valid_reg && (value_reg > new_value);

    // Shift up on insert, shift down on drain, hold otherwise
    always_comb
    begin
        value_next = value_reg;
        valid_next = valid_reg;
        priority if (ctrl.drain)
        begin
            value_next = next_value;
            valid_next = next_valid;
        end
        else if (ctrl.insert)
        begin
            if (gt || (!valid_reg && prev_valid))
            begin
                value_next = prev_gt ? prev_value : new_value;
                valid_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
    end

    assign value = value_reg;
    assign valid = valid_reg;

endmodule

FILE: design/insertion_sorter.sv
`timescale 1ns / 1ps
// Insertion: one item per cycle while not busy; each value takes its place in the cell chain the next cycle.
// Output: the set drains from the bottom cell, one result per cycle for N stored
// entries, starting the cycle after the last item; busy is high while the set drains.
// No new item is accepted while busy, so a set must drain before the next set goes in.
// Reset clears all valid bits, the drop flag and the drain state; values are unreset.
// Results are shown for one cycle each with done; the receiver cannot stall.
module insertion_sorter #(
    parameter int MAX_ITEMS = 16
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    output logic                 busy,
    input  isort_pkg::in_item_t  item,
    output logic                 done,
    output isort_pkg::out_item_t result
);

    isort_pkg::value_t    cell_value [MAX_ITEMS];
    logic                 cell_valid [MAX_ITEMS];
    logic                 cell_gt    [MAX_ITEMS];
    isort_pkg::cell_ctrl_t ctrl;

    logic accept;
    logic full;
    logic drain_reg;
    logic drain_next;
    logic drop_reg;
    logic drop_next;
    logic drain_end;

    assign accept    = start && !drain_reg;
    assign full      = cell_valid[MAX_ITEMS-1];
    assign drain_end = drain_reg && !cell_valid[1];

    assign ctrl.insert = accept && !full;
    assign ctrl.drain  = drain_reg;

    // Build the chain: each cell sees its lower and upper neighbor
    for (genvar i = 0; i < MAX_ITEMS; i++)
    begin : g_cell
        isort_pkg::value_t p_value;
        logic              p_valid;
        logic              p_gt;
        isort_pkg::value_t n_value;
        logic              n_valid;

        if (i == 0)
        begin : g_bottom
            assign p_value = item.value;
            assign p_valid = 1'b1;
            assign p_gt    = 1'b0;
        end
        else
        begin : g_lower
            assign p_value = cell_value[i-1];
            assign p_valid = cell_valid[i-1];
            assign p_gt    = cell_gt[i-1];
        end

        if (i == MAX_ITEMS - 1)
        begin : g_top
            assign n_value = '0;
            assign n_valid = 1'b0;
        end
        else
        begin : g_upper
            assign n_value = cell_value[i+1];
            assign n_valid = cell_valid[i+1];
        end

        isort_cell u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .ctrl       (ctrl),
            .new_value  (item.value),
            .prev_value (p_value),
            .prev_valid (p_valid),
            .prev_gt    (p_gt),
            .next_value (n_value),
            .next_valid (n_valid),
            .value      (cell_value[i]),
            .valid      (cell_valid[i]),
            .gt         (cell_gt[i])
        );
    end

    // Start draining after the last item, stop on the last result
    always_comb
    begin
        drain_next = drain_reg;
        drop_next  = drop_reg;
        priority if (drain_end)
        begin
            drain_next = 1'b0;
            drop_next  = 1'b0;
        end
        else if (accept)
        begin
            drain_next = item.last_item;
            if (full)
            begin
                drop_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            drain_reg <= 1'b0;
            drop_reg  <= 1'b0;
        end
        else
        begin
            drain_reg <= drain_next;
            drop_reg  <= drop_next;
        end
    end

    // Present the bottom cell while draining
    assign busy                = drain_reg;
    assign done                = drain_reg;
    assign result.sorted_value = cell_value[0];
    assign result.last_result  = !cell_valid[1];
    assign result.overflow     = drop_reg;

`ifndef SYNTHESIS
    a_last_starts_drain: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && item.last_item) |=> done)
        else $error("last item did not start the drain");

    a_drain_continues: assert property (@(posedge clk) disable iff (!rst_n)
        (done && !result.last_result) |=> done)
        else $error("drain stopped before the last result");

    a_drain_stops: assert property (@(posedge clk) disable iff (!rst_n)
        (done && result.last_result) |=> (!busy && !cell_valid[0] && !drop_reg))
        else $error("chain not empty after the last result");

    a_drain_has_entry: assert property (@(posedge clk) disable iff (!rst_n)
        busy |-> cell_valid[0])
        else $error("result emitted from an empty cell");
`endif

endmodule

FILE: bench/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

    localparam int MAX_ITEMS = 16;
    localparam int CLK_PERIOD = 20;
    localparam isort_pkg::value_t VAL_MAX = 32'sh7FFF_FFFF;
    localparam isort_pkg::value_t VAL_MIN = 32'sh8000_0000;

    // Value shapes drawn for random sets
    typedef enum int {
        SHAPE_ANY,
        SHAPE_NARROW,
        SHAPE_EXTREME,
        SHAPE_FALLING
    } value_shape_t;

    logic                 clk;
    logic                 rst_n;
    logic                 start;
    logic                 busy;
    isort_pkg::in_item_t  item;
    logic                 done;
    isort_pkg::out_item_t result;

    // Own copy of the sorted store, used to predict each drained set
    isort_pkg::value_t    model_store [MAX_ITEMS];
    int                   model_count;
    bit                   model_dropped;

    isort_pkg::out_item_t sorted_due [$];
    isort_pkg::out_item_t sorted_head;
    int                   mismatch_count;
    int                   sender_idle_pct;

    insertion_sorter #(
        .MAX_ITEMS(MAX_ITEMS)
    ) dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .busy   (busy),
        .item   (item),
        .done   (done),
        .result (result)
    );

    initial
    begin
        clk = 1'b0;
        forever #(CLK_PERIOD / 2) clk = ~clk;
    end

    // Insert one value into the model store; on end of set, queue the sorted results
    task automatic insert_and_drain(input isort_pkg::value_t v, input logic last);
        int                   pos;
        isort_pkg::out_item_t r;
        if (model_count < MAX_ITEMS)
        begin
            pos = model_count;
            while (pos > 0 && model_store[pos - 1] > v)
            begin
                model_store[pos] = model_store[pos - 1];
                pos--;
            end
            model_store[pos] = v;
            model_count++;
        end
        else
        begin
            model_dropped = 1'b1;
        end
        if (last)
        begin
            for (int k = 0; k < model_count; k++)
            begin
                r.sorted_value = model_store[k];
                r.last_result  = (k + 1 == model_count);
                r.overflow     = model_dropped;
                sorted_due.push_back(r);
            end
            model_count   = 0;
            model_dropped = 1'b0;
        end
    endtask

    // Present one item after a random idle stretch and hold it until accepted
    task automatic send_item(input isort_pkg::value_t v, input logic last);
        int gap;
        gap = 0;
        while ($urandom_range(99) < sender_idle_pct && gap < 40)
            gap++;
        if (gap > 0)
        begin
            @(negedge clk);
            start <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        start <= 1'b1;
        item  <= isort_pkg::in_item_t'{value: v, last_item: last};
        do
            @(posedge clk);
        while (busy);
        insert_and_drain(v, last);
    endtask

    // Check each drained result against the oldest prediction
    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            if (sorted_due.size() == 0)
            begin
                $display("%0t: unexpected result value=%0d last=%b ovf=%b", $time,
                         result.sorted_value, result.last_result, result.overflow);
                mismatch_count++;
            end
            else
            begin
                sorted_head = sorted_due.pop_front();
                if (result.sorted_value !== sorted_head.sorted_value)
                begin
                    $display("%0t: sorted_value expected %0d actual %0d", $time,
                             sorted_head.sorted_value, result.sorted_value);
                    mismatch_count++;
                end
                if (result.last_result !== sorted_head.last_result)
                begin
                    $display("%0t: last_result expected %b actual %b", $time,
                             sorted_head.last_result, result.last_result);
                    mismatch_count++;
                end
                if (result.overflow !== sorted_head.overflow)
                begin
                    $display("%0t: overflow expected %b actual %b", $time,
                             sorted_head.overflow, result.overflow);
                    mismatch_count++;
                end
            end
        end
    end

    // Extremes of the value range, with a repeated maximum
    task automatic test_extreme_values();
        send_item(VAL_MAX, 1'b0);
        send_item(32'sd0, 1'b0);
        send_item(VAL_MIN, 1'b0);
        send_item(-32'sd1, 1'b0);
        send_item(VAL_MAX, 1'b1);
    endtask

    // Sets of one item each
    task automatic test_single_item_sets();
        send_item(VAL_MIN, 1'b1);
        send_item(VAL_MAX, 1'b1);
    endtask

    // Fill the store with falling values, then drop two, the final one included
    task automatic test_store_overflow();
        for (int i = 0; i < MAX_ITEMS + 2; i++)
            send_item(isort_pkg::value_t'(1000 - 37 * i), i == MAX_ITEMS + 1);
    endtask

    // Random sets until roughly item_budget items have gone in
    task automatic test_random_sets(input int idle_pct, input int item_budget);
        int                sent;
        int                set_len;
        int                pick;
        value_shape_t      shape;
        isort_pkg::value_t v;
        isort_pkg::value_t prev;
        sent = 0;
        sender_idle_pct = idle_pct;
        while (sent < item_budget)
        begin
            pick = $urandom_range(99);
            if (pick < 10)
                set_len = $urandom_range(MAX_ITEMS + 1, MAX_ITEMS + 6);
            else if (pick < 25)
                set_len = MAX_ITEMS;
            else
                set_len = $urandom_range(1, MAX_ITEMS - 1);
            shape = value_shape_t'($urandom_range(3));
            prev  = $urandom;
            for (int i = 0; i < set_len; i++)
            begin
                case (shape)
                    SHAPE_NARROW:  v = isort_pkg::value_t'($urandom_range(8)) - 32'sd4;
                    SHAPE_EXTREME:
                    begin
                        case ($urandom_range(3))
                            0:       v = VAL_MAX;
                            1:       v = VAL_MIN;
                            2:       v = 32'sd0;
                            default: v = -32'sd1;
                        endcase
                    end
                    SHAPE_FALLING:
                    begin
                        v    = prev - isort_pkg::value_t'($urandom_range(50000));
                        prev = v;
                    end
                    default:       v = $urandom;
                endcase
                send_item(v, i == set_len - 1);
                sent++;
            end
        end
    endtask

    initial
    begin
        rst_n           = 1'b0;
        start           = 1'b0;
        item            = '0;
        model_count     = 0;
        model_dropped   = 1'b0;
        mismatch_count  = 0;
        sender_idle_pct = 35;
        repeat (5) @(negedge clk);
        rst_n <= 1'b1;

        test_extreme_values();
        test_single_item_sets();
        test_store_overflow();
        test_random_sets(35, 150);
        test_random_sets(56, 150);
        test_random_sets(0, 150);

        // Drop start and let the last set drain
        @(negedge clk);
        start <= 1'b0;
        while (sorted_due.size() != 0)
            @(posedge clk);
        repeat (MAX_ITEMS + 8) @(posedge clk);

        if (mismatch_count == 0 && sorted_due.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

    // Bound the run well past the slowest legal schedule
    initial
    begin
        #5_000_000;
        $display("Regression FAIL");
        $finish;
    end

endmodule
